// ===== src/kar_pkg.sv =====
// kar_pkg: shared constants, command codes and queue types for the key auto-repeat block
// no dependencies; used by kar_front, kar_fifo, kar_back and key_auto_repeat_core
package kar_pkg;

    localparam int TIME_W    = 48;
    localparam int KEY_W     = 8;
    localparam int CMD_W     = 2;
    localparam int INIT_W    = 22;
    localparam int RPT_W     = 21;
    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 8;

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam int DIV_RADIX = 4;
    localparam int DIV_STEPS = TIME_W / DIV_RADIX;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [INIT_W-1:0] INIT_DELAY_RST = 22'd300000;
    localparam logic [RPT_W-1:0]  RPT_DELAY_RST  = 21'd100000;
    localparam logic [TIME_W-1:0] TIME_MAX       = '1;

    localparam logic [CMD_W-1:0] CMD_DOWN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RPT  = 1'b1;

    typedef enum logic [1:0] {
        KIND_DOWN,
        KIND_UP,
        KIND_TICK
    } kar_kind_t;

    typedef struct packed {
        kar_kind_t         kind;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
    } kar_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } kar_qstat_t;

endpackage

// ===== src/kar_front.sv =====
// kar_front: accepts input transactions, classifies them and pushes work into the queue
// depends on kar_pkg; feeds kar_fifo
module kar_front (
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [kar_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [kar_pkg::CMD_W-1:0]  s_tuser,
    input  kar_pkg::kar_qstat_t        q_stat,
    output logic                       push,
    output kar_pkg::kar_item_t         push_item
);

    function automatic logic is_repeatable(input logic [kar_pkg::KEY_W-1:0] k);
        logic rep;
        rep = 1'b1;
        unique case (k) inside
            [8'h00:8'h03], 8'h28, 8'h29, 8'h2B, 8'h39,
            [8'h46:8'h49], 8'h53, 8'h58, 8'h65, 8'h66,
            [8'h74:8'h7F], [8'h87:8'h8B], [8'h90:8'h94],
            [8'hE0:8'hE9], 8'hEC, 8'hEF, 8'hF0, 8'hF3, 8'hF4,
            [8'hF7:8'hFB]: rep = 1'b0;
            default:       rep = 1'b1;
        endcase
        return rep;
    endfunction

    logic [kar_pkg::KEY_W-1:0]  key;
    logic [kar_pkg::TIME_W-1:0] now;
    logic                       keep;
    kar_pkg::kar_kind_t         kind;

    assign key = s_tdata[kar_pkg::KEY_W-1:0];
    assign now = s_tdata[kar_pkg::KEY_W +: kar_pkg::TIME_W];

    // non-repeatable key downs and unknown commands have no effect and are dropped here
    always_comb begin
        keep = 1'b0;
        kind = kar_pkg::KIND_TICK;
        unique case (s_tuser)
            kar_pkg::CMD_DOWN: begin
                keep = is_repeatable(key);
                kind = kar_pkg::KIND_DOWN;
            end
            kar_pkg::CMD_UP: begin
                keep = 1'b1;
                kind = kar_pkg::KIND_UP;
            end
            kar_pkg::CMD_TICK: begin
                keep = 1'b1;
                kind = kar_pkg::KIND_TICK;
            end
            default: begin
                keep = 1'b0;
                kind = kar_pkg::KIND_TICK;
            end
        endcase
    end

    assign s_tready       = !q_stat.full;
    assign push           = s_tvalid && !q_stat.full && keep;
    assign push_item.kind = kind;
    assign push_item.key  = key;
    assign push_item.now  = now;

endmodule

// ===== src/kar_fifo.sv =====
// kar_fifo: short queue of classified events between front and back
// depends on kar_pkg
module kar_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  kar_pkg::kar_item_t  push_item,
    input  logic                pop,
    output kar_pkg::kar_item_t  head_item,
    output kar_pkg::kar_qstat_t q_stat
);

    kar_pkg::kar_item_t          entry_reg [kar_pkg::QDEPTH];
    logic [kar_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [kar_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [kar_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        do_push, do_pop;

    assign q_stat.full  = (count_reg == kar_pkg::QCNT_W'(kar_pkg::QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_item    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == kar_pkg::QPTR_W'(kar_pkg::QDEPTH - 1)) ? '0
                                                                               : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == kar_pkg::QPTR_W'(kar_pkg::QDEPTH - 1)) ? '0
                                                                               : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/kar_back.sv =====
// kar_back: repeat tracker state, deadline catch-up with a radix-16 remainder unit, result register
// depends on kar_pkg; drains kar_fifo
module kar_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [kar_pkg::INIT_W-1:0]  initial_delay_us,
    input  logic [kar_pkg::RPT_W-1:0]   repeat_delay_us,
    input  kar_pkg::kar_item_t          head_item,
    input  kar_pkg::kar_qstat_t         q_stat,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [kar_pkg::M_DATA_W-1:0] m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX
    } state_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_DELAY,
        MODE_REPEAT
    } mode_t;

    state_t                        state_reg, state_next;
    mode_t                         mode_reg, mode_next;
    logic [kar_pkg::KEY_W-1:0]     held_key_reg, held_key_next;
    logic [kar_pkg::TIME_W-1:0]    deadline_reg, deadline_next;
    logic [kar_pkg::TIME_W-1:0]    now_reg, now_next;
    logic [kar_pkg::TIME_W-1:0]    gap_reg, gap_next;
    logic [kar_pkg::RPT_W-1:0]     rem_reg, rem_next;
    logic [kar_pkg::RPT_W-1:0]     delay_reg, delay_next;
    logic [kar_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [kar_pkg::KEY_W-1:0]     out_key_reg, out_key_next;

    logic                          out_free;
    logic                          mode_active;
    logic                          tick_due;
    logic [kar_pkg::TIME_W-1:0]    tick_gap;
    logic [kar_pkg::TIME_W:0]      down_sum;
    logic [kar_pkg::RPT_W-1:0]     fix_add;
    logic [kar_pkg::TIME_W:0]      fix_sum;
    logic [kar_pkg::RPT_W-1:0]     div_rem;
    logic [kar_pkg::RPT_W:0]       div_trial;

    assign out_free    = !out_valid_reg || m_tready;
    assign mode_active = (mode_reg == MODE_DELAY) || (mode_reg == MODE_REPEAT);
    assign tick_due    = mode_active && (head_item.now >= deadline_reg);
    assign tick_gap    = head_item.now - deadline_reg;
    assign down_sum    = {1'b0, head_item.now} + (kar_pkg::TIME_W + 1)'(initial_delay_us);
    assign fix_add     = (rem_reg == '0) ? '0 : delay_reg - rem_reg;
    assign fix_sum     = {1'b0, now_reg} + (kar_pkg::TIME_W + 1)'(fix_add);
    assign pop         = (state_reg == ST_IDLE) && !q_stat.empty && out_free;

    // remainder of gap by the repeat delay, DIV_RADIX quotient bits per cycle, msb first
    always_comb begin
        div_rem   = rem_reg;
        div_trial = '0;
        for (int i = 0; i < kar_pkg::DIV_RADIX; i++) begin
            div_trial = {div_rem, gap_reg[kar_pkg::TIME_W-1-i]};
            if (div_trial >= {1'b0, delay_reg}) begin
                div_trial = div_trial - {1'b0, delay_reg};
            end
            div_rem = div_trial[kar_pkg::RPT_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        held_key_next  = held_key_reg;
        deadline_next  = deadline_reg;
        now_next       = now_reg;
        gap_next       = gap_reg;
        rem_next       = rem_reg;
        delay_next     = delay_reg;
        cnt_next       = cnt_reg;
        out_key_next   = out_key_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    unique case (head_item.kind)
                        kar_pkg::KIND_DOWN: begin
                            mode_next     = MODE_DELAY;
                            held_key_next = head_item.key;
                            deadline_next = down_sum[kar_pkg::TIME_W] ? kar_pkg::TIME_MAX
                                                                      : down_sum[kar_pkg::TIME_W-1:0];
                        end
                        kar_pkg::KIND_UP: begin
                            if (mode_active && (held_key_reg == head_item.key)) begin
                                mode_next = MODE_IDLE;
                            end
                        end
                        kar_pkg::KIND_TICK: begin
                            if (tick_due) begin
                                mode_next      = MODE_REPEAT;
                                out_valid_next = 1'b1;
                                out_key_next   = held_key_reg;
                                if (tick_gap != '0) begin
                                    if (repeat_delay_us == '0) begin
                                        deadline_next = head_item.now;
                                    end else begin
                                        now_next   = head_item.now;
                                        gap_next   = tick_gap;
                                        delay_next = repeat_delay_us;
                                        rem_next   = '0;
                                        cnt_next   = '0;
                                        state_next = ST_DIV;
                                    end
                                end
                            end
                        end
                        default: begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                rem_next = div_rem;
                gap_next = gap_reg << kar_pkg::DIV_RADIX;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == kar_pkg::DIV_CNT_W'(kar_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                deadline_next = fix_sum[kar_pkg::TIME_W] ? kar_pkg::TIME_MAX
                                                         : fix_sum[kar_pkg::TIME_W-1:0];
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_IDLE;
            held_key_reg  <= '0;
            deadline_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            held_key_reg  <= held_key_next;
            deadline_reg  <= deadline_next;
            out_valid_reg <= out_valid_next;
        end
        now_reg     <= now_next;
        gap_reg     <= gap_next;
        rem_reg     <= rem_next;
        delay_reg   <= delay_next;
        cnt_reg     <= cnt_next;
        out_key_reg <= out_key_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_key_reg;

endmodule

// ===== src/key_auto_repeat_core.sv =====
// key_auto_repeat_core: top level of the key auto-repeat tracker, holds the delay registers
// depends on kar_pkg, kar_front, kar_fifo, kar_back
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tuser cmd[1:0]; tdata key_code[7:0], now_us[55:8]
// m_        out  m_tvalid/m_tready  tdata repeat_key[7:0]
// cfg_      in   cfg_wr_en          cfg_index 0 initial_delay_us, 1 repeat_delay_us
//
// key down, key up and a tick that needs no catch-up are handled in ST_IDLE in the back end
// a due tick with the deadline behind now and a nonzero repeat delay goes on to ST_DIV,
// the radix-16 remainder unit over the 48-bit gap, and ST_FIX fixes up the deadline
// a two-entry queue lets the input side keep accepting while the back end works
// the back end waits when the result register is still full
// reset is synchronous: idle mode, empty queue, default delays
module key_auto_repeat_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [kar_pkg::S_DATA_W-1:0]   s_tdata,   // key_code[7:0], now_us[55:8]
    input  logic [kar_pkg::CMD_W-1:0]      s_tuser,   // cmd[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kar_pkg::M_DATA_W-1:0]   m_tdata,   // repeat_key[7:0]
    input  logic                           cfg_wr_en,
    input  logic [kar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kar_pkg::CFG_W-1:0]      cfg_wdata
);

    logic [kar_pkg::INIT_W-1:0] initial_delay_reg;
    logic [kar_pkg::RPT_W-1:0]  repeat_delay_reg;

    kar_pkg::kar_qstat_t q_stat;
    kar_pkg::kar_item_t  push_item;
    kar_pkg::kar_item_t  head_item;
    logic                push;
    logic                pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_delay_reg <= kar_pkg::INIT_DELAY_RST;
            repeat_delay_reg  <= kar_pkg::RPT_DELAY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                kar_pkg::CFG_IDX_INIT: initial_delay_reg <= cfg_wdata[kar_pkg::INIT_W-1:0];
                kar_pkg::CFG_IDX_RPT:  repeat_delay_reg  <= cfg_wdata[kar_pkg::RPT_W-1:0];
                default: begin
                    initial_delay_reg <= initial_delay_reg;
                end
            endcase
        end
    end

    kar_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    kar_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    kar_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .initial_delay_us (initial_delay_reg),
        .repeat_delay_us  (repeat_delay_reg),
        .head_item        (head_item),
        .q_stat           (q_stat),
        .pop              (pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule
